/* hdl/wlac_pkg.sv */
// shared types, constants and blend function for the layer compositor
`default_nettype none
package wlac_pkg;

   localparam int MAX_SLOT_DIM = 256;
   localparam int PIXEL_W      = 32;
   localparam int CFG_W        = 9;
   localparam int COUNT_W      = $clog2(MAX_SLOT_DIM);
   localparam int CALC_W       = ((CFG_W > COUNT_W) ? CFG_W : COUNT_W) + 2;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] REG_SLOT_WIDTH     = 2'd0;
   localparam logic [1:0] REG_SLOT_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_ITEM_SIZE      = 2'd2;
   localparam logic [1:0] REG_OVERLAY_ENABLE = 2'd3;

   localparam logic [CFG_W-1:0] RESET_SLOT_WIDTH  = 9'd48;
   localparam logic [CFG_W-1:0] RESET_SLOT_HEIGHT = 9'd48;
   localparam logic [CFG_W-1:0] RESET_ITEM_SIZE   = 9'd32;

   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic [CFG_W-1:0] slot_width;
      logic [CFG_W-1:0] slot_height;
      logic [CFG_W-1:0] window_side;
      logic             overlay_enable;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] background;
      logic [PIXEL_W-1:0] frame;
      logic [PIXEL_W-1:0] item;
      logic [PIXEL_W-1:0] overlay;
      logic               use_item;
      logic               use_overlay;
      logic               last;
   } job_type;

   // one colour channel of the weighted sum
   function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                      input logic [7:0] a);
      logic [15:0] sum;
      sum = ({8'h00, s} * {8'h00, a}) + ({8'h00, d} * {8'h00, ALPHA_OPAQUE - a});
      return sum[15:8];
   endfunction

   // src over dst, background alpha kept on partial alpha
   function automatic logic [PIXEL_W-1:0] blend(input logic [PIXEL_W-1:0] dst,
                                                input logic [PIXEL_W-1:0] src);
      logic [7:0] a;
      a = src[31:24];
      if (a == ALPHA_CLEAR) begin
         return dst;
      end else if (a == ALPHA_OPAQUE) begin
         return src;
      end
      return {dst[31:24], mix(src[23:16], dst[23:16], a),
              mix(src[15:8], dst[15:8], a), mix(src[7:0], dst[7:0], a)};
   endfunction

endpackage
`default_nettype wire

/* hdl/windowed_layer_alpha_compositor_core.sv */
// top level of the windowed ARGB8888 layer compositor
// Pixels of one slot rectangle arrive in raster order, one request per pixel,
// and each request yields exactly one composited pixel. The front end tracks
// the raster position and classifies the pixel against the item window, set
// at the width-centred offset on both axes; a two-entry queue decouples it
// from a three-stage blend pipeline (frame, item, overlay), one blend per
// stage. Sustained rate is one pixel per clock while rsp_stall is low; an
// accepted request is written into the queue, then passes through the three
// pipeline registers before it is offered. Configuration writes are always
// accepted and should only be made while the block is idle.
`default_nettype none
module windowed_layer_alpha_compositor_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_background_pixel,
   input  wire logic [31:0] req_frame_pixel,
   input  wire logic [31:0] req_item_pixel,
   input  wire logic [31:0] req_overlay_pixel,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_out_pixel,
   output logic             rsp_last_of_slot,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);

   wlac_pkg::cfg_type cfg_ff, cfg_in;
   wlac_pkg::job_type front_job, queue_job;
   logic queue_full, queue_not_empty, queue_pop, req_accept;

   always_comb begin
      csr_ready  = 1'b1;
      req_stall  = queue_full;
      req_accept = req_valid && !queue_full;
      cfg_in     = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wlac_pkg::REG_SLOT_WIDTH:     cfg_in.slot_width     = csr_wdata;
            wlac_pkg::REG_SLOT_HEIGHT:    cfg_in.slot_height    = csr_wdata;
            wlac_pkg::REG_ITEM_SIZE:      cfg_in.window_side    = csr_wdata;
            wlac_pkg::REG_OVERLAY_ENABLE: cfg_in.overlay_enable = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_width     <= wlac_pkg::RESET_SLOT_WIDTH;
         cfg_ff.slot_height    <= wlac_pkg::RESET_SLOT_HEIGHT;
         cfg_ff.window_side    <= wlac_pkg::RESET_ITEM_SIZE;
         cfg_ff.overlay_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wlac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (req_accept),
      .background (req_background_pixel),
      .frame      (req_frame_pixel),
      .item       (req_item_pixel),
      .overlay    (req_overlay_pixel),
      .job        (front_job)
   );

   wlac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_job  (front_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_job   (queue_job)
   );

   wlac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job       (queue_job),
      .job_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_pixel (rsp_out_pixel),
      .rsp_last  (rsp_last_of_slot)
   );

endmodule
`default_nettype wire

/* hdl/wlac_front.sv */
// front end: raster position tracking and window classification
`default_nettype none
module wlac_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wlac_pkg::cfg_type cfg,
   input  wire logic              accept,
   input  wire logic [wlac_pkg::PIXEL_W-1:0] background,
   input  wire logic [wlac_pkg::PIXEL_W-1:0] frame,
   input  wire logic [wlac_pkg::PIXEL_W-1:0] item,
   input  wire logic [wlac_pkg::PIXEL_W-1:0] overlay,
   output wlac_pkg::job_type      job
);

   logic [wlac_pkg::COUNT_W-1:0] column_count_ff, column_count_in;
   logic [wlac_pkg::COUNT_W-1:0] row_count_ff, row_count_in;

   logic [wlac_pkg::CALC_W-1:0] w, h, item_sz, off, x, y, lim, w_raw, h_raw;
   logic in_window, end_row, end_slot;

   localparam logic [wlac_pkg::CALC_W-1:0] ONE     = wlac_pkg::CALC_W'(1);
   localparam logic [wlac_pkg::CALC_W-1:0] DIM_MAX =
      wlac_pkg::CALC_W'(wlac_pkg::MAX_SLOT_DIM);

   always_comb begin
      w_raw   = wlac_pkg::CALC_W'(cfg.slot_width);
      h_raw   = wlac_pkg::CALC_W'(cfg.slot_height);
      item_sz = wlac_pkg::CALC_W'(cfg.window_side);
      x       = wlac_pkg::CALC_W'(column_count_ff);
      y       = wlac_pkg::CALC_W'(row_count_ff);

      if (w_raw == '0) begin
         w = ONE;
      end else if (w_raw > DIM_MAX) begin
         w = DIM_MAX;
      end else begin
         w = w_raw;
      end
      if (h_raw == '0) begin
         h = ONE;
      end else if (h_raw > DIM_MAX) begin
         h = DIM_MAX;
      end else begin
         h = h_raw;
      end

      off = (item_sz < w) ? ((w - item_sz) >> 1) : '0;
      lim = off + item_sz;
      in_window = (x >= off) && (x < lim) && (y >= off) && (y < lim);
      end_row   = x >= (w - ONE);
      end_slot  = end_row && (y >= (h - ONE));

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (end_row) begin
            column_count_in = '0;
            row_count_in    = end_slot ? '0 : row_count_ff + 1'b1;
         end else begin
            column_count_in = column_count_ff + 1'b1;
         end
      end

      job.background  = background;
      job.frame       = frame;
      job.item        = item;
      job.overlay     = overlay;
      job.use_item    = in_window;
      job.use_overlay = in_window && cfg.overlay_enable;
      job.last        = end_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/wlac_queue.sv */
// short request queue between front end and blend pipeline
`default_nettype none
module wlac_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire wlac_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output wlac_pkg::job_type      pop_job
);

   wlac_pkg::job_type entry_ff [wlac_pkg::QUEUE_DEPTH];
   logic [wlac_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [wlac_pkg::QCNT_W-1:0] count_ff, count_in;

   localparam logic [wlac_pkg::QPTR_W-1:0] LAST_PTR =
      wlac_pkg::QPTR_W'(wlac_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      full      = count_ff == wlac_pkg::QCNT_W'(wlac_pkg::QUEUE_DEPTH);
      not_empty = count_ff != '0;
      pop_job   = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

/* hdl/wlac_back.sv */
// back end: three-stage blend pipeline; the third stage register drives the response
`default_nettype none
module wlac_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire wlac_pkg::job_type job,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [wlac_pkg::PIXEL_W-1:0] rsp_pixel,
   output logic                   rsp_last
);

   logic advance;

   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [wlac_pkg::PIXEL_W-1:0] s1_pixel_ff, s1_pixel_in;
   logic [wlac_pkg::PIXEL_W-1:0] s1_item_ff, s1_overlay_ff;
   logic                         s1_use_item_ff, s1_use_overlay_ff, s1_last_ff;
   logic [wlac_pkg::PIXEL_W-1:0] s2_pixel_ff, s2_pixel_in, s2_overlay_ff;
   logic                         s2_use_overlay_ff, s2_last_ff;
   logic [wlac_pkg::PIXEL_W-1:0] s3_pixel_ff, s3_pixel_in;
   logic                         s3_last_ff;

   always_comb begin
      advance     = !s3_valid_ff || !rsp_stall;
      job_pop     = advance && job_valid;
      s1_pixel_in = wlac_pkg::blend(job.background, job.frame);
      s2_pixel_in = s1_use_item_ff ? wlac_pkg::blend(s1_pixel_ff, s1_item_ff) : s1_pixel_ff;
      s3_pixel_in = s2_use_overlay_ff ? wlac_pkg::blend(s2_pixel_ff, s2_overlay_ff)
                                      : s2_pixel_ff;
      rsp_valid   = s3_valid_ff;
      rsp_pixel   = s3_pixel_ff;
      rsp_last    = s3_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= job_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pixel_ff       <= s1_pixel_in;
         s1_item_ff        <= job.item;
         s1_overlay_ff     <= job.overlay;
         s1_use_item_ff    <= job.use_item;
         s1_use_overlay_ff <= job.use_overlay;
         s1_last_ff        <= job.last;
         s2_pixel_ff       <= s2_pixel_in;
         s2_overlay_ff     <= s1_overlay_ff;
         s2_use_overlay_ff <= s1_use_overlay_ff;
         s2_last_ff        <= s1_last_ff;
         s3_pixel_ff       <= s3_pixel_in;
         s3_last_ff        <= s2_last_ff;
      end
   end

endmodule
`default_nettype wire
